/* hw/rtl/fidr_pkg.sv */
// Package for the frequency and idle residency counter.
// Holds the sizes, the mode, status and register codes and the command and status
// structs shared by the controller, the datapath and the checker. No dependencies.
package fidr_pkg;

   // Matrix dimensions.
   localparam int MAX_LEVELS = 32;
   localparam int MAX_IDLE   = 8;
   localparam int CELLS      = MAX_LEVELS * MAX_IDLE;

   localparam int LEVEL_W = $clog2(MAX_LEVELS);
   localparam int IDLE_W  = $clog2(MAX_IDLE);
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int K_W     = (LEVEL_W > IDLE_W) ? LEVEL_W : IDLE_W;
   localparam int NF_W    = $clog2(MAX_LEVELS + 1);
   localparam int NI_W    = $clog2(MAX_IDLE + 1);

   // Item fields.
   localparam int MODE_W   = 3;
   localparam int KHZ_W    = 22;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 2;

   // Configuration port.
   localparam int FREQ_COUNT_W = 6;
   localparam int IDLE_COUNT_W = 4;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 6;

   // Division by 1000, one 4-bit digit per step.
   localparam int DIVISOR     = 1000;
   localparam int DIV_DIGIT_W = 4;
   localparam int DIV_RADIX   = 1 << DIV_DIGIT_W;
   localparam int DIV_REM_W   = $clog2(DIVISOR);
   localparam int DIV_X_W     = DIV_REM_W + DIV_DIGIT_W;
   localparam int DIV_STEPS   = VALUE_W / DIV_DIGIT_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   // Quotient widths that feed the weighting multiplier.
   localparam int MHZ_W   = $clog2(((1 << KHZ_W) - 1) / DIVISOR + 1);
   localparam int QCELL_W = VALUE_W - $clog2(DIVISOR) + 1;

   // Item modes.
   localparam logic [MODE_W-1:0] MODE_TICK        = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SET_IDLE    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SET_FREQ    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LOAD_KHZ    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ_CELL   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_LEVEL_TOTAL = 3'd5;
   localparam logic [MODE_W-1:0] MODE_WEIGHTED    = 3'd6;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DISABLED = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FREQ_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_COUNT = 2'd2;

   // Counter memory read address sources.
   localparam logic [1:0] RD_TICK   = 2'd0;
   localparam logic [1:0] RD_SUM    = 2'd1;
   localparam logic [1:0] RD_WEIGHT = 2'd2;

   typedef struct packed {
      logic                capture;
      logic                acc_clr;
      logic                acc_add_cell;
      logic                acc_add_prod;
      logic                k_load;
      logic                k_from_req;
      logic                k_inc;
      logic                set_idle;
      logic                set_freq;
      logic                load;
      logic                tick_wr;
      logic                div_start;
      logic                rsp_load;
      logic [1:0]          rd_sel;
      logic [STATUS_W-1:0] status;
   } fidr_cmd_type;

   typedef struct packed {
      logic enable;
      logic idle_ok;
      logic freq_ok;
      logic load_ok;
      logic k_last_idle;
      logic k_last_level;
      logic div_done;
   } fidr_stat_type;

endpackage

/* hw/rtl/fidr_if.sv */
// Channel interfaces of the frequency and idle residency counter.
// Request, response and register-write channels, each with valid and ready.
// Depends on fidr_pkg for the field widths.
interface fidr_req_if;
   logic                               valid;
   logic                               ready;
   logic [fidr_pkg::MODE_W-1:0]        mode;
   logic [fidr_pkg::IDLE_W-1:0]        idle_index;
   logic [fidr_pkg::LEVEL_W-1:0]       freq_index;
   logic [fidr_pkg::KHZ_W-1:0]         freq_khz;

   modport source (output valid, mode, idle_index, freq_index, freq_khz, input ready);
   modport sink   (input valid, mode, idle_index, freq_index, freq_khz, output ready);
endinterface

interface fidr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [fidr_pkg::VALUE_W-1:0]       value;
   logic [fidr_pkg::STATUS_W-1:0]      status;

   modport source (output valid, value, status, input ready);
   modport sink   (input valid, value, status, output ready);
endinterface

interface fidr_csr_if;
   logic                               valid;
   logic                               ready;
   logic [fidr_pkg::CSR_INDEX_W-1:0]   index;
   logic [fidr_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/fidr_div1000.sv */
// Iterative divider by the constant 1000 for the residency counter.
// Retires one 4-bit quotient digit per cycle, 16 digits for a 64-bit dividend.
// Depends on fidr_pkg.
module fidr_div1000 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fidr_pkg::VALUE_W-1:0]  dividend,
   output logic [fidr_pkg::VALUE_W-1:0]  quotient,
   output logic                          done
);

   function automatic logic [fidr_pkg::DIV_X_W-1:0] div_multiple(
      input logic [fidr_pkg::DIV_DIGIT_W-1:0] d);
      return fidr_pkg::DIV_X_W'(int'(d) * fidr_pkg::DIVISOR);
   endfunction

   logic [fidr_pkg::VALUE_W-1:0]     work_ff, work_in;
   logic [fidr_pkg::DIV_REM_W-1:0]   rem_ff, rem_in;
   logic [fidr_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [fidr_pkg::DIV_X_W-1:0]     x;
   logic [fidr_pkg::DIV_X_W-1:0]     x_less;
   logic [fidr_pkg::DIV_DIGIT_W-1:0] digit;

   // Partial remainder with the next digit of the dividend appended. The digit
   // is the largest d for which d*1000 fits; the thresholds are monotonic.
   always_comb begin
      x = {rem_ff, work_ff[fidr_pkg::VALUE_W-1 -: fidr_pkg::DIV_DIGIT_W]};
      digit = '0;
      for (int d = 1; d < fidr_pkg::DIV_RADIX; d++) begin
         if (x >= div_multiple(fidr_pkg::DIV_DIGIT_W'(d))) begin
            digit = fidr_pkg::DIV_DIGIT_W'(d);
         end
      end
      x_less = x - div_multiple(digit);
   end

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = {work_ff[fidr_pkg::VALUE_W-fidr_pkg::DIV_DIGIT_W-1:0], digit};
         rem_in  = x_less[fidr_pkg::DIV_REM_W-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == fidr_pkg::DIV_CNT_W'(fidr_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign quotient = work_ff;
   assign done     = done_ff;

endmodule

/* hw/rtl/fidr_ctrl.sv */
// Controller state machine of the residency counter.
// Sequences ticks, queries and the weighted walk; drives fidr_dp through a command
// struct and reads its status struct. Depends on fidr_pkg.
module fidr_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fidr_pkg::MODE_W-1:0]       req_mode,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  fidr_pkg::fidr_stat_type           stat,
   output fidr_pkg::fidr_cmd_type            cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_TICK_RD = 4'd1;
   localparam logic [3:0] S_TICK_WR = 4'd2;
   localparam logic [3:0] S_SUM_RD  = 4'd3;
   localparam logic [3:0] S_SUM_ACC = 4'd4;
   localparam logic [3:0] S_W_RD    = 4'd5;
   localparam logic [3:0] S_W_START = 4'd6;
   localparam logic [3:0] S_W_DIV   = 4'd7;
   localparam logic [3:0] S_W_ACC   = 4'd8;
   localparam logic [3:0] S_DONE    = 4'd9;

   logic [3:0]                    state_ff, state_in;
   logic                          one_cell_ff, one_cell_in;
   logic [fidr_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;

   always_comb begin
      cmd          = '0;
      cmd.rd_sel   = fidr_pkg::RD_TICK;
      cmd.status   = status_ff;
      state_in     = state_ff;
      one_cell_in  = one_cell_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_mode)
                  fidr_pkg::MODE_TICK: begin
                     if (stat.enable) begin
                        state_in = S_TICK_RD;
                     end
                  end
                  fidr_pkg::MODE_SET_IDLE: begin
                     cmd.set_idle = stat.enable & stat.idle_ok;
                  end
                  fidr_pkg::MODE_SET_FREQ: begin
                     cmd.set_freq = stat.enable & stat.freq_ok;
                  end
                  fidr_pkg::MODE_LOAD_KHZ: begin
                     cmd.load = stat.load_ok;
                  end
                  fidr_pkg::MODE_READ_CELL, fidr_pkg::MODE_LEVEL_TOTAL,
                  fidr_pkg::MODE_WEIGHTED: begin
                     cmd.capture    = 1'b1;
                     cmd.acc_clr    = 1'b1;
                     cmd.k_load     = 1'b1;
                     cmd.k_from_req = (req_mode == fidr_pkg::MODE_READ_CELL);
                     one_cell_in    = (req_mode == fidr_pkg::MODE_READ_CELL);
                     status_in      = fidr_pkg::ST_OK;
                     if (!stat.enable) begin
                        status_in = fidr_pkg::ST_DISABLED;
                        state_in  = S_DONE;
                     end else if (req_mode == fidr_pkg::MODE_WEIGHTED) begin
                        state_in = S_W_RD;
                     end else if (stat.freq_ok &&
                                  (stat.idle_ok || req_mode != fidr_pkg::MODE_READ_CELL)) begin
                        state_in = S_SUM_RD;
                     end else begin
                        status_in = fidr_pkg::ST_RANGE;
                        state_in  = S_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_TICK_RD: begin
            state_in = S_TICK_WR;
         end
         S_TICK_WR: begin
            cmd.tick_wr = 1'b1;
            state_in    = S_IDLE;
         end
         S_SUM_RD: begin
            cmd.rd_sel = fidr_pkg::RD_SUM;
            state_in   = S_SUM_ACC;
         end
         S_SUM_ACC: begin
            cmd.acc_add_cell = 1'b1;
            if (one_cell_ff || stat.k_last_idle) begin
               state_in = S_DONE;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = S_SUM_RD;
            end
         end
         S_W_RD: begin
            cmd.rd_sel = fidr_pkg::RD_WEIGHT;
            state_in   = S_W_START;
         end
         S_W_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_W_DIV;
         end
         S_W_DIV: begin
            if (stat.div_done) begin
               state_in = S_W_ACC;
            end
         end
         S_W_ACC: begin
            cmd.acc_add_prod = 1'b1;
            if (stat.k_last_level) begin
               state_in = S_DONE;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = S_W_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         one_cell_ff  <= 1'b0;
         status_ff    <= fidr_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         one_cell_ff  <= one_cell_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* hw/rtl/fidr_dp.sv */
// Datapath of the residency counter: registers, counter memory with valid flags,
// frequency table, two divide-by-1000 units, weighting multiplier and accumulator.
// Depends on fidr_pkg and fidr_div1000.
module fidr_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  fidr_pkg::fidr_cmd_type              cmd,
   output fidr_pkg::fidr_stat_type             stat,
   input  logic [fidr_pkg::IDLE_W-1:0]         req_idle_index,
   input  logic [fidr_pkg::LEVEL_W-1:0]        req_freq_index,
   input  logic [fidr_pkg::KHZ_W-1:0]          req_freq_khz,
   input  logic                                csr_we,
   input  logic [fidr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fidr_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic [fidr_pkg::VALUE_W-1:0]        rsp_value,
   output logic [fidr_pkg::STATUS_W-1:0]       rsp_status
);

   function automatic logic [fidr_pkg::ADDR_W-1:0] cell_addr(
      input logic [fidr_pkg::IDLE_W-1:0]  idle,
      input logic [fidr_pkg::NF_W-1:0]    n,
      input logic [fidr_pkg::LEVEL_W-1:0] lvl);
      logic [fidr_pkg::ADDR_W-1:0] a;
      logic [fidr_pkg::ADDR_W-1:0] b;
      a = fidr_pkg::ADDR_W'(idle);
      b = fidr_pkg::ADDR_W'(n);
      return a * b + fidr_pkg::ADDR_W'(lvl);
   endfunction

   // Configuration and current state.
   logic                                enable_ff;
   logic [fidr_pkg::FREQ_COUNT_W-1:0]   freq_count_ff;
   logic [fidr_pkg::IDLE_COUNT_W-1:0]   idle_count_ff;
   logic [fidr_pkg::IDLE_W-1:0]         cur_idle_ff;
   logic [fidr_pkg::LEVEL_W-1:0]        cur_level_ff;
   logic [fidr_pkg::NF_W-1:0]           nf;
   logic [fidr_pkg::NI_W-1:0]           ni;

   // Query working registers.
   logic [fidr_pkg::LEVEL_W-1:0]        idx_f_ff;
   logic [fidr_pkg::K_W-1:0]            k_ff;
   logic [fidr_pkg::VALUE_W-1:0]        acc_ff;

   // Counter memory.
   logic [fidr_pkg::VALUE_W-1:0]        res_mem [fidr_pkg::CELLS];
   logic [fidr_pkg::CELLS-1:0]          valid_ff;
   logic [fidr_pkg::VALUE_W-1:0]        rd_data_ff;
   logic                                rd_valid_ff;
   logic [fidr_pkg::ADDR_W-1:0]         rd_addr;
   logic [fidr_pkg::ADDR_W-1:0]         tick_addr;
   logic [fidr_pkg::VALUE_W-1:0]        cell_val;

   // Frequency table.
   logic [fidr_pkg::KHZ_W-1:0]          khz_mem [fidr_pkg::MAX_LEVELS];
   logic [fidr_pkg::KHZ_W-1:0]          khz_rd_ff;

   // Weighting.
   logic [fidr_pkg::VALUE_W-1:0]        q_cell;
   logic [fidr_pkg::VALUE_W-1:0]        q_khz;
   logic                                done_cell;
   logic                                done_khz;
   logic [fidr_pkg::MHZ_W+fidr_pkg::QCELL_W-1:0] prod_full;
   logic [fidr_pkg::VALUE_W-1:0]        prod_ff;

   logic [fidr_pkg::VALUE_W-1:0]        rsp_value_ff;
   logic [fidr_pkg::STATUS_W-1:0]       rsp_status_ff;

   // Counts clamped into their legal ranges.
   always_comb begin
      if (freq_count_ff == '0) begin
         nf = fidr_pkg::NF_W'(1);
      end else if (int'(freq_count_ff) > fidr_pkg::MAX_LEVELS) begin
         nf = fidr_pkg::NF_W'(fidr_pkg::MAX_LEVELS);
      end else begin
         nf = fidr_pkg::NF_W'(freq_count_ff);
      end
      if (int'(idle_count_ff) < 2) begin
         ni = fidr_pkg::NI_W'(2);
      end else if (int'(idle_count_ff) > fidr_pkg::MAX_IDLE) begin
         ni = fidr_pkg::NI_W'(fidr_pkg::MAX_IDLE);
      end else begin
         ni = fidr_pkg::NI_W'(idle_count_ff);
      end
   end

   assign stat.enable       = enable_ff;
   assign stat.idle_ok      = fidr_pkg::NI_W'(req_idle_index) < ni;
   assign stat.freq_ok      = fidr_pkg::NF_W'(req_freq_index) < nf;
   assign stat.load_ok      = int'(req_freq_index) < fidr_pkg::MAX_LEVELS;
   assign stat.k_last_idle  = (k_ff == fidr_pkg::K_W'(ni - 1'b1));
   assign stat.k_last_level = (k_ff == fidr_pkg::K_W'(nf - 1'b1));
   assign stat.div_done     = done_cell & done_khz;

   assign tick_addr = cell_addr(cur_idle_ff, nf, cur_level_ff);

   always_comb begin
      case (cmd.rd_sel)
         fidr_pkg::RD_SUM: begin
            rd_addr = cell_addr(k_ff[fidr_pkg::IDLE_W-1:0], nf, idx_f_ff);
         end
         fidr_pkg::RD_WEIGHT: begin
            rd_addr = cell_addr('0, nf, k_ff[fidr_pkg::LEVEL_W-1:0]);
         end
         default: begin
            rd_addr = tick_addr;
         end
      endcase
   end

   // A cell never ticked since reset reads as zero.
   assign cell_val = rd_valid_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.tick_wr) begin
         res_mem[tick_addr] <= cell_val + 1'b1;
      end
      rd_data_ff <= res_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.tick_wr) begin
         valid_ff[tick_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         khz_mem[req_freq_index] <= req_freq_khz;
      end
      khz_rd_ff <= khz_mem[k_ff[fidr_pkg::LEVEL_W-1:0]];
   end

   fidr_div1000 u_div_cell (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cell_val),
      .quotient (q_cell),
      .done     (done_cell)
   );

   fidr_div1000 u_div_khz (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (fidr_pkg::VALUE_W'(khz_rd_ff)),
      .quotient (q_khz),
      .done     (done_khz)
   );

   assign prod_full = q_khz[fidr_pkg::MHZ_W-1:0] * q_cell[fidr_pkg::QCELL_W-1:0];

   always_ff @(posedge clock) begin
      prod_ff <= prod_full[fidr_pkg::VALUE_W-1:0];
   end

   // Configuration and current indices.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         freq_count_ff <= fidr_pkg::FREQ_COUNT_W'(1);
         idle_count_ff <= fidr_pkg::IDLE_COUNT_W'(2);
         cur_idle_ff   <= '0;
         cur_level_ff  <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               fidr_pkg::CSR_ENABLE: begin
                  enable_ff <= csr_data[0];
               end
               fidr_pkg::CSR_FREQ_COUNT: begin
                  freq_count_ff <= csr_data[fidr_pkg::FREQ_COUNT_W-1:0];
               end
               fidr_pkg::CSR_IDLE_COUNT: begin
                  idle_count_ff <= csr_data[fidr_pkg::IDLE_COUNT_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (cmd.set_idle) begin
            cur_idle_ff <= req_idle_index;
         end
         if (cmd.set_freq) begin
            cur_level_ff <= req_freq_index;
         end
      end
   end

   // Query working registers and the result register.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_f_ff <= req_freq_index;
      end
      if (cmd.k_load) begin
         k_ff <= cmd.k_from_req ? fidr_pkg::K_W'(req_idle_index) : '0;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (cmd.acc_add_cell) begin
         acc_ff <= acc_ff + cell_val;
      end else if (cmd.acc_add_prod) begin
         acc_ff <= acc_ff + prod_ff;
      end
      if (cmd.rsp_load) begin
         rsp_value_ff  <= acc_ff;
         rsp_status_ff <= cmd.status;
      end
   end

   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

/* hw/rtl/freq_idle_residency_counter_top.sv */
// Set-idle, set-freq and load items are handled in the idle state; a tick reads and then writes its cell.
// A cell read reads and adds its one cell; a level total walks every idle state of its level.
// A weighted query runs the 16-step divide-by-1000 once for each frequency level in turn.
// One item is worked at a time; the response register lets a new item in while it waits.
// Reset is synchronous and active high; the counter matrix reads zero right after it.
// The frequency table is not cleared and must be loaded before a weighted query.
module freq_idle_residency_counter_top (
   input logic            clock,
   input logic            reset,
   fidr_req_if.sink       req_bus,
   fidr_rsp_if.source     rsp_bus,
   fidr_csr_if.sink       csr_bus
);

   // The controller and the datapath talk only through these two structs.
   fidr_pkg::fidr_cmd_type  cmd;
   fidr_pkg::fidr_stat_type stat;

   logic req_ready;
   logic rsp_valid;

   // Register writes are always taken; the block is expected to be idle when they come.
   assign csr_bus.ready = 1'b1;

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

   // The controller sequences each item: ticks become a read-modify-write of the
   // current cell, queries walk the counter memory cell by cell, reading and then adding
   // each, and weighted queries run both dividers once per frequency level.
   fidr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .req_mode  (req_bus.mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds all storage. Counters that were never ticked since reset
   // are masked by a per-cell valid flag, so reset clears the whole matrix at once.
   fidr_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_idle_index (req_bus.idle_index),
      .req_freq_index (req_bus.freq_index),
      .req_freq_khz   (req_bus.freq_khz),
      .csr_we         (csr_bus.valid & csr_bus.ready),
      .csr_index      (csr_bus.index),
      .csr_data       (csr_bus.data),
      .rsp_value      (rsp_bus.value),
      .rsp_status     (rsp_bus.status)
   );

endmodule

/* hw/rtl/fidr_checker.sv */
// Port-level checks for the residency counter, bound to its top level.
// Depends on fidr_pkg and freq_idle_residency_counter_top.
module fidr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [fidr_pkg::MODE_W-1:0]         req_mode,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [fidr_pkg::VALUE_W-1:0]        rsp_value,
   input logic [fidr_pkg::STATUS_W-1:0]       rsp_status
);

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("response changed while stalled");

   // Error responses carry a zero value.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != fidr_pkg::ST_OK |-> rsp_value == '0)
      else $error("error response with nonzero value");

   // An accepted query makes the block busy in the next cycle.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == fidr_pkg::MODE_READ_CELL ||
      req_mode == fidr_pkg::MODE_LEVEL_TOTAL || req_mode == fidr_pkg::MODE_WEIGHTED)
      |=> !req_ready)
      else $error("query accepted without leaving idle");

   // A new response only appears at the end of a busy period.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response raised while idle");

endmodule

bind freq_idle_residency_counter_top fidr_checker u_fidr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_mode   (req_bus.mode),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_value  (rsp_bus.value),
   .rsp_status (rsp_bus.status)
);

/* verif/fidr_tb_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard class for the frequency and idle residency counter testbench.
// Predicts the counter matrix, the frequency table and the query results.
// Depends on fidr_pkg for sizes and codes.
package fidr_tb_pkg;
   import fidr_pkg::*;

   localparam logic [MODE_W-1:0]      MODE_SPARE  = 3'd7;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE   = 2'd3;
   localparam logic [VALUE_W-1:0]     KHZ_PER_MHZ = 64'd1000;
   localparam logic [VALUE_W-1:0]     US_PER_MS   = 64'd1000;
   localparam int                     PRINT_LIMIT = 100;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
   } query_result_t;

   class residency_scoreboard;
      logic [VALUE_W-1:0]      residency [CELLS];
      logic [KHZ_W-1:0]        level_khz [MAX_LEVELS];
      logic [IDLE_W-1:0]       cur_idle;
      logic [LEVEL_W-1:0]      cur_level;
      logic                    enabled;
      logic [FREQ_COUNT_W-1:0] freq_count;
      logic [IDLE_COUNT_W-1:0] idle_count;
      query_result_t           awaited_q [$];
      int unsigned             fail_count;

      function new();
         foreach (residency[i]) residency[i] = '0;
         foreach (level_khz[i]) level_khz[i] = '0;
         cur_idle   = '0;
         cur_level  = '0;
         enabled    = 1'b0;
         freq_count = 6'd1;
         idle_count = 4'd2;
         fail_count = 0;
      endfunction

      function int unsigned levels_used();
         if (freq_count < 1) return 1;
         if (freq_count > MAX_LEVELS) return MAX_LEVELS;
         return freq_count;
      endfunction

      function int unsigned idles_used();
         if (idle_count < 2) return 2;
         if (idle_count > MAX_IDLE) return MAX_IDLE;
         return idle_count;
      endfunction

      function int unsigned pending_count();
         return awaited_q.size();
      endfunction

      function logic [VALUE_W-1:0] cell_of(int unsigned idle, int unsigned level);
         return residency[idle * levels_used() + level];
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ENABLE:     enabled    = data[0];
            CSR_FREQ_COUNT: freq_count = data[FREQ_COUNT_W-1:0];
            CSR_IDLE_COUNT: idle_count = data[IDLE_COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // Applies one accepted item and queues the result it causes, if any.
      function void note_item(logic [MODE_W-1:0] mode, logic [IDLE_W-1:0] idle_i,
                              logic [LEVEL_W-1:0] freq_i, logic [KHZ_W-1:0] khz);
         int unsigned        nf;
         int unsigned        ni;
         int unsigned        pos;
         logic [VALUE_W-1:0] mhz;
         query_result_t      res;
         nf = levels_used();
         ni = idles_used();
         res.value  = '0;
         res.status = ST_OK;
         case (mode)
            MODE_LOAD_KHZ: begin
               if (freq_i < MAX_LEVELS) level_khz[freq_i] = khz;
            end
            MODE_TICK: begin
               if (enabled) begin
                  pos = cur_idle * nf + cur_level;
                  if (pos < CELLS) residency[pos] = residency[pos] + 1;
               end
            end
            MODE_SET_IDLE: begin
               if (enabled && idle_i < ni) cur_idle = idle_i;
            end
            MODE_SET_FREQ: begin
               if (enabled && freq_i < nf) cur_level = freq_i;
            end
            MODE_READ_CELL, MODE_LEVEL_TOTAL, MODE_WEIGHTED: begin
               if (!enabled) begin
                  res.status = ST_DISABLED;
               end else if (mode == MODE_READ_CELL) begin
                  if (idle_i < ni && freq_i < nf) res.value = cell_of(idle_i, freq_i);
                  else res.status = ST_RANGE;
               end else if (mode == MODE_LEVEL_TOTAL) begin
                  if (freq_i < nf) begin
                     for (int k = 0; k < ni; k++) res.value += cell_of(k, freq_i);
                  end else begin
                     res.status = ST_RANGE;
                  end
               end else begin
                  for (int k = 0; k < nf; k++) begin
                     mhz = '0;
                     mhz[KHZ_W-1:0] = level_khz[k];
                     res.value += (mhz / KHZ_PER_MHZ) * (cell_of(0, k) / US_PER_MS);
                  end
               end
               awaited_q.push_back(res);
            end
            default: ;
         endcase
      endfunction

      task report(string msg);
         fail_count++;
         if (fail_count <= PRINT_LIMIT) $display("MISMATCH: %s", msg);
      endtask

      task check_result(logic [VALUE_W-1:0] value, logic [STATUS_W-1:0] status);
         query_result_t want;
         if (awaited_q.size() == 0) begin
            report($sformatf("unexpected result value 0x%0h status %0d", value, status));
            return;
         end
         want = awaited_q.pop_front();
         if (value !== want.value)
            report($sformatf("value 0x%0h, predicted 0x%0h", value, want.value));
         if (status !== want.status)
            report($sformatf("status %0d, predicted %0d", status, want.status));
      endtask

      task final_check();
         if (awaited_q.size() != 0)
            report($sformatf("%0d predicted results never arrived", awaited_q.size()));
      endtask
   endclass

endpackage

/* verif/freq_idle_residency_counter_top_tb.sv */
`timescale 1ns / 100ps
// Top-level testbench of the frequency and idle residency counter.
// Drives the request and register channels, checks every response against the scoreboard.
// Depends on fidr_pkg, the channel interfaces and fidr_tb_pkg.
module freq_idle_residency_counter_top_tb;
   import fidr_pkg::*;
   import fidr_tb_pkg::*;

   localparam int          RESET_CYCLES   = 11;
   localparam int          HOLD_CYCLES    = 400;
   localparam int          SETTLE_CYCLES  = 16;
   // The slowest query is a weighted sum over all 32 levels.
   localparam int          DRAIN_CYCLES   = 700;
   localparam int          WATCHDOG_LIMIT = 6000;
   localparam int          SEGMENTS       = 8;
   localparam int          SEGMENT_ITEMS  = 200;
   localparam logic [KHZ_W-1:0] KHZ_MAX   = {KHZ_W{1'b1}};

   logic clock;
   logic reset;

   fidr_req_if req_bus ();
   fidr_rsp_if rsp_bus ();
   fidr_csr_if csr_bus ();

   freq_idle_residency_counter_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   residency_scoreboard board;

   // Percent of cycles in which the sender holds back and the receiver stalls.
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   // Set by the main sequence to start one long receiver hold-off.
   logic        hold_request  = 1'b0;
   int unsigned hold_left     = 0;
   int unsigned quiet_cycles  = 0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The receiver decides ready at each falling edge. A requested hold-off keeps
   // ready low for a long stretch so that the block fills and pushes back on requests.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         rsp_bus.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready = ($urandom_range(99) >= stall_pct);
      end
   end

   // Responses are sampled at the rising edge and compared with the oldest prediction.
   always @(posedge clock) begin
      if (board != null && reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         board.check_result(rsp_bus.value, rsp_bus.status);
   end

   // The watchdog ends the run when no channel has moved an item for too long.
   always @(posedge clock) begin
      if (reset !== 1'b0) begin
         quiet_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                   (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one item from the falling edge on and returns at the rising edge that
   // accepts it. Valid stays high until the next call or a settle changes it, so it
   // is never lowered and raised within the same time step.
   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [IDLE_W-1:0] idle_i,
                            input logic [LEVEL_W-1:0] freq_i, input logic [KHZ_W-1:0] khz);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.mode       = mode;
      req_bus.idle_index = idle_i;
      req_bus.freq_index = freq_i;
      req_bus.freq_khz   = khz;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      board.note_item(mode, idle_i, freq_i, khz);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = data;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      board.write_reg(idx, data);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Stops offering requests and waits until every predicted result has arrived.
   // Items without a result are given the extra pause to finish.
   task automatic settle(input int unsigned pause);
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (board.pending_count() != 0) @(posedge clock);
      repeat (pause) @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] en, input logic [CSR_DATA_W-1:0] fc,
                            input logic [CSR_DATA_W-1:0] ic);
      settle(SETTLE_CYCLES);
      write_reg(CSR_ENABLE, en);
      write_reg(CSR_FREQ_COUNT, fc);
      write_reg(CSR_IDLE_COUNT, ic);
   endtask

   task automatic tick_run(input int unsigned count);
      repeat (count) send_item(MODE_TICK, $urandom_range(7), $urandom_range(31), $urandom);
   endtask

   // Ticks lead the mix and indices are mostly in range, so that cells build up and
   // queries find nonzero counters; the rest probes out-of-range indices and the spare mode.
   task automatic random_item();
      int unsigned        pick;
      logic [MODE_W-1:0]  mode;
      logic [IDLE_W-1:0]  idle_i;
      logic [LEVEL_W-1:0] freq_i;
      logic [KHZ_W-1:0]   khz;
      pick = $urandom_range(99);
      if (pick < 35)      mode = MODE_TICK;
      else if (pick < 47) mode = MODE_SET_IDLE;
      else if (pick < 59) mode = MODE_SET_FREQ;
      else if (pick < 67) mode = MODE_LOAD_KHZ;
      else if (pick < 80) mode = MODE_READ_CELL;
      else if (pick < 90) mode = MODE_LEVEL_TOTAL;
      else if (pick < 97) mode = MODE_WEIGHTED;
      else                mode = MODE_SPARE;
      if ($urandom_range(9) < 8) idle_i = $urandom_range(board.idles_used() - 1);
      else idle_i = $urandom_range(7);
      // Going back to the active state often keeps the weighted sum moving.
      if (mode == MODE_SET_IDLE && $urandom_range(2) == 0) idle_i = '0;
      if ($urandom_range(9) < 8) freq_i = $urandom_range(board.levels_used() - 1);
      else freq_i = $urandom_range(31);
      pick = $urandom_range(9);
      if (pick == 0)      khz = '0;
      else if (pick == 1) khz = KHZ_MAX;
      else                khz = $urandom_range(KHZ_MAX);
      send_item(mode, idle_i, freq_i, khz);
   endtask

   initial begin
      logic [KHZ_W-1:0] khz;
      board = new();
      req_bus.valid      = 1'b0;
      req_bus.mode       = '0;
      req_bus.idle_index = '0;
      req_bus.freq_index = '0;
      req_bus.freq_khz   = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = '0;
      csr_bus.data       = '0;
      reset              = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // While the block is not enabled, queries report so and updates are dropped.
      send_item(MODE_READ_CELL, 3'd0, 5'd0, '0);
      send_item(MODE_LEVEL_TOTAL, 3'd0, 5'd0, '0);
      send_item(MODE_WEIGHTED, 3'd0, 5'd0, '0);
      send_item(MODE_TICK, 3'd0, 5'd0, '0);
      send_item(MODE_SET_IDLE, 3'd1, 5'd0, '0);
      send_item(MODE_SPARE, 3'd7, 5'd31, KHZ_MAX);

      // The whole frequency table is loaded up front, so that no weighted query
      // ever reads an entry that was never written. Loads work while disabled.
      for (int k = 0; k < MAX_LEVELS; k++) begin
         case (k)
            0:       khz = KHZ_MAX;
            1:       khz = '0;
            2:       khz = 22'd999;
            3:       khz = 22'd1000;
            default: khz = $urandom_range(KHZ_MAX);
         endcase
         send_item(MODE_LOAD_KHZ, $urandom_range(7), k, khz);
      end

      configure(1, 4, 3);
      write_reg(CSR_SPARE, $urandom_range(63));

      // Directed updates and queries, with both in-range and out-of-range indices.
      send_item(MODE_SET_IDLE, 3'd2, 5'd0, '0);
      send_item(MODE_SET_FREQ, 3'd0, 5'd3, '0);
      tick_run(3);
      send_item(MODE_READ_CELL, 3'd2, 5'd3, '0);
      send_item(MODE_READ_CELL, 3'd0, 5'd0, '0);
      send_item(MODE_READ_CELL, 3'd3, 5'd0, '0);
      send_item(MODE_READ_CELL, 3'd0, 5'd4, '0);
      send_item(MODE_READ_CELL, 3'd7, 5'd31, KHZ_MAX);
      send_item(MODE_SET_IDLE, 3'd7, 5'd0, '0);
      send_item(MODE_SET_FREQ, 3'd0, 5'd31, '0);
      tick_run(1);
      send_item(MODE_LEVEL_TOTAL, 3'd0, 5'd3, '0);
      send_item(MODE_LEVEL_TOTAL, 3'd0, 5'd4, '0);
      send_item(MODE_LEVEL_TOTAL, 3'd7, 5'd31, '0);
      send_item(MODE_WEIGHTED, 3'd0, 5'd0, '0);
      send_item(MODE_SPARE, 3'd0, 5'd0, '0);

      // Shrinking the counts keeps the current indices, so the next tick lands on a
      // cell that the new layout maps elsewhere.
      configure(1, 2, 2);
      tick_run(1);
      send_item(MODE_READ_CELL, 3'd1, 5'd1, '0);
      send_item(MODE_LEVEL_TOTAL, 3'd0, 5'd1, '0);

      // Long tick runs push active cells past a thousand microseconds, so that the
      // weighted busy value becomes nonzero.
      send_item(MODE_LOAD_KHZ, 3'd0, 5'd1, 22'd2000000);
      send_item(MODE_SET_IDLE, 3'd0, 5'd0, '0);
      send_item(MODE_SET_FREQ, 3'd0, 5'd0, '0);
      tick_run(1100);
      send_item(MODE_SET_FREQ, 3'd0, 5'd1, '0);
      tick_run(1050);
      send_item(MODE_WEIGHTED, 3'd0, 5'd0, '0);
      send_item(MODE_READ_CELL, 3'd0, 5'd1, '0);
      send_item(MODE_LEVEL_TOTAL, 3'd0, 5'd0, '0);

      // Random segments. Each takes one idling pattern and one register setting;
      // the first ones cover the extremes, the clamped values among them.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0:       configure(1, 32, 8);
            1:       configure(1, 1, 2);
            2:       configure(1, 0, 0);
            3:       configure(1, 63, 15);
            4:       configure(0, 5, 4);
            default: configure(($urandom_range(9) != 0), $urandom_range(63), $urandom_range(63));
         endcase
         case (seg % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 80;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 80;
            end
            default: begin
               send_idle_pct = 19;
               stall_pct     = 19;
            end
         endcase
         if (seg == 0) begin
            // The receiver holds off while cell reads keep coming.
            hold_request = 1'b1;
            repeat (40) send_item(MODE_READ_CELL, $urandom_range(7), $urandom_range(31), '0);
         end
         repeat (SEGMENT_ITEMS) random_item();
      end

      settle(DRAIN_CYCLES);
      board.final_check();
      if (board.fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/fidr_pkg.sv
hw/rtl/fidr_if.sv
hw/rtl/fidr_div1000.sv
hw/rtl/fidr_ctrl.sv
hw/rtl/fidr_dp.sv
hw/rtl/freq_idle_residency_counter_top.sv
hw/rtl/fidr_checker.sv
verif/fidr_tb_pkg.sv
verif/freq_idle_residency_counter_top_tb.sv
